// ===== sv/variable_width_table_crc_hash_defines.svh =====
// assertion helpers shared by the hash block
`ifndef VARIABLE_WIDTH_TABLE_CRC_HASH_DEFINES_SVH
`define VARIABLE_WIDTH_TABLE_CRC_HASH_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VWCH_ASSERT_NOW(name, clk_i, rst_ni, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vwch assertion failed");

// next-cycle implication, disabled during reset
`define VWCH_ASSERT_NEXT(name, clk_i, rst_ni, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vwch assertion failed");

`endif

// ===== sv/vwch_pkg.sv =====
`default_nettype none

package vwch_pkg;

  // field widths
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned HASH_OUT_W    = 32;
  localparam int unsigned CFG_W         = 6;
  localparam int unsigned POLY_W        = 64;
  localparam int unsigned MIN_HASH_BITS = 16;

  // seed and full-length polynomial
  localparam logic [HASH_OUT_W-1:0] SEED      = 32'h0CD5_E44A;
  localparam logic [POLY_W-1:0]     POLY_FULL = 64'h0060_0340_00F0_D50B;

  typedef logic [CFG_W-1:0]  width_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam width_t MIN_WIDTH = width_t'(MIN_HASH_BITS);

  // one input word as held in the input stage
  typedef struct packed {
    byte_t data_byte;
    logic  first_byte;
  } in_word_t;

endpackage

`default_nettype wire

// ===== sv/vwch_step.sv =====
`default_nettype none

module vwch_step #(
  parameter int unsigned HASH_W = 32
) (
  input  wire vwch_pkg::width_t   hash_width,
  input  wire logic [HASH_W-1:0]  hash,
  input  wire vwch_pkg::in_word_t word,
  output logic [HASH_W-1:0]       hash_nxt
);

  logic [5:0]                  mask_sh;
  logic [HASH_W-1:0]           mask;
  logic [6:0]                  poly_sh;
  logic [vwch_pkg::POLY_W-1:0] poly_full_sh;
  logic [HASH_W-1:0]           poly;
  logic [HASH_W-1:0]           base;
  vwch_pkg::width_t            top_sh;
  vwch_pkg::byte_t             top_byte;
  logic [HASH_W-1:0]           reduce;

  // width mask and polynomial for the active width
  assign mask_sh      = 6'(HASH_W) - hash_width;
  assign mask         = {HASH_W{1'b1}} >> mask_sh;
  assign poly_sh      = 7'(vwch_pkg::POLY_W) - {1'b0, hash_width};
  assign poly_full_sh = vwch_pkg::POLY_FULL >> poly_sh;
  assign poly         = poly_full_sh[HASH_W-1:0] | HASH_W'(1);

  // restart from the masked seed on a first byte
  assign base = word.first_byte ? (vwch_pkg::SEED[HASH_W-1:0] & mask) : hash;

  // top byte sits at bits width-1 .. width-8
  assign top_sh   = hash_width - vwch_pkg::width_t'(vwch_pkg::BYTE_W);
  assign top_byte = vwch_pkg::byte_t'(base >> top_sh);

  // carry-less product of top byte and polynomial
  always_comb begin
    reduce = '0;
    for (int k = 0; k < vwch_pkg::BYTE_W; k++) begin
      if (top_byte[k]) begin
        reduce = reduce ^ (poly << k);
      end
    end
  end

  // shift in the new byte and fold in the reduction term
  assign hash_nxt = ((base << vwch_pkg::BYTE_W) ^ HASH_W'(word.data_byte) ^ reduce) & mask;

endmodule

`default_nettype wire

// ===== sv/variable_width_table_crc_hash.sv =====
// Byte-wise CRC-style hash with a hash width selectable from 16 to MAX_HASH_BITS.
// Input channel: in_valid/in_ready carry one message byte per word, with
// in_first_byte set on the first byte of a message to restart from the seed.
// Output channel: out_valid/out_ready return the running hash after every byte,
// zero above the active width.
// Configuration: cfg_wr_en writes cfg_wr_data as the hash width; values below 16
// act as 16 and values above MAX_HASH_BITS act as MAX_HASH_BITS. Write it only
// while no word is in flight.
// Pipeline: a byte passes the input register and then the hash register, which
// doubles as the output register. The update is a single XOR network, so one
// byte every cycle while the receiver keeps taking results.
// A stalled receiver holds the hash register; one more byte waits in the input
// register, after which in_ready drops until the result is taken.
// Reset clears both valids, sets the width to MAX_HASH_BITS and loads the seed,
// so bytes without a leading first byte continue from the seed.
`default_nettype none
`include "variable_width_table_crc_hash_defines.svh"

module variable_width_table_crc_hash #(
  parameter int unsigned MAX_HASH_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [vwch_pkg::BYTE_W-1:0]         in_data_byte,
  input  wire logic                                in_first_byte,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [vwch_pkg::HASH_OUT_W-1:0]          out_hash_value,
  input  wire logic                                cfg_wr_en,
  input  wire logic [vwch_pkg::CFG_W-1:0]          cfg_wr_data
);

  localparam int unsigned      HW        = MAX_HASH_BITS;
  localparam vwch_pkg::width_t MAX_WIDTH = vwch_pkg::width_t'(MAX_HASH_BITS);

  vwch_pkg::width_t   hash_width_r;
  vwch_pkg::width_t   hash_width_nxt;
  logic               s1_valid_r;
  vwch_pkg::in_word_t s1_word_r;
  logic               out_valid_r;
  logic [HW-1:0]      hash_r;
  logic [HW-1:0]      hash_nxt;
  logic               s1_adv;

  // clamp the written width to the supported range
  always_comb begin
    if (cfg_wr_data < vwch_pkg::MIN_WIDTH) begin
      hash_width_nxt = vwch_pkg::MIN_WIDTH;
    end else if (cfg_wr_data > MAX_WIDTH) begin
      hash_width_nxt = MAX_WIDTH;
    end else begin
      hash_width_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_width_r <= MAX_WIDTH;
    end else if (cfg_wr_en) begin
      hash_width_r <= hash_width_nxt;
    end
  end

  // handshake: the input stage moves on when the output slot is free or taken
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= '{data_byte: in_data_byte, first_byte: in_first_byte};
    end
  end

  // hash update network
  vwch_step #(
    .HASH_W (HW)
  ) u_step (
    .hash_width (hash_width_r),
    .hash       (hash_r),
    .word       (s1_word_r),
    .hash_nxt   (hash_nxt)
  );

  // running hash, also the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hash_r      <= vwch_pkg::SEED[HW-1:0];
    end else begin
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_valid_r && s1_adv) begin
        hash_r <= hash_nxt;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = vwch_pkg::HASH_OUT_W'(hash_r);

  // checks
  `VWCH_ASSERT_NEXT(a_hash_upper_zero, clk, rst_n, s1_valid_r && s1_adv, (out_hash_value >> $past(hash_width_r)) == '0)
  `VWCH_ASSERT_NEXT(a_hash_hold, clk, rst_n, !(s1_valid_r && s1_adv), $stable(hash_r))
  `VWCH_ASSERT_NOW(a_width_range, clk, rst_n, 1'b1, (hash_width_r >= vwch_pkg::MIN_WIDTH) && (hash_width_r <= MAX_WIDTH))

endmodule

`default_nettype wire
